// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in the same cycle implies consequent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/psx_pkg.sv
// Package: shared constants of the printable string extractor.
`timescale 1ns / 1ps
package psx_pkg;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned MIN_W         = 6;
  localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7e;
  localparam logic [MIN_W-1:0] MIN_LEN_LO    = 6'd3;
  localparam logic [MIN_W-1:0] MIN_LEN_HI    = 6'd32;
  localparam logic [MIN_W-1:0] MIN_LEN_RESET = 6'd4;
endpackage

// File: rtl/printable_string_extractor.sv
// Order: ending byte -> queued command -> first character in the output register.
// Throughput: a byte per cycle while a bank is free; a char per cycle out while ready.
// Two run banks: with two strings pending, input stalls until the older one drains.
// Reset: counters and queue cleared, min_length = 4; bank memory needs no clearing.
// Top level: printable string extractor.
`timescale 1ns / 1ps
module printable_string_extractor #(
  parameter int unsigned RUN_CAPACITY = 64,
  parameter int unsigned STRING_LIMIT = 128,
  parameter int unsigned SCAN_LIMIT   = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,     // min_length
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // limit_reached
);
  localparam int unsigned LW = $clog2(RUN_CAPACITY + 1);
  localparam int unsigned AW = $clog2(RUN_CAPACITY);

  logic                       wr_en, push, pop, q_valid, q_full;
  logic [AW:0]                wr_addr;
  logic [psx_pkg::CHAR_W-1:0] wr_data;
  logic [LW+1:0]              cmd, head;

  psx_front #(
    .RUN_CAPACITY(RUN_CAPACITY),
    .STRING_LIMIT(STRING_LIMIT),
    .SCAN_LIMIT  (SCAN_LIMIT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  psx_cmdq #(
    .W(LW + 2)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .head_o (head)
  );

  psx_drain #(
    .RUN_CAPACITY(RUN_CAPACITY)
  ) u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .cmd_valid_i(q_valid),
    .cmd_i      (head),
    .cmd_pop_o  (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_user_o   (m_axis_tuser)
  );
endmodule

// File: rtl/psx_front.sv
// Front end: classifies bytes, fills the run banks and queues drain commands.
`timescale 1ns / 1ps
module psx_front #(
  parameter int unsigned RUN_CAPACITY = 64,
  parameter int unsigned STRING_LIMIT = 128,
  parameter int unsigned SCAN_LIMIT   = 65536,
  localparam int unsigned LW = $clog2(RUN_CAPACITY + 1),
  localparam int unsigned AW = $clog2(RUN_CAPACITY),
  localparam int unsigned SW = $clog2(STRING_LIMIT + 1),
  localparam int unsigned BW = $clog2(SCAN_LIMIT + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [psx_pkg::MIN_W-1:0]      cfg_data_i,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [psx_pkg::CHAR_W-1:0]     s_data_i,
  input  logic                           s_last_i,
  input  logic                           q_full_i,
  output logic                           wr_en_o,
  output logic [AW:0]                    wr_addr_o,
  output logic [psx_pkg::CHAR_W-1:0]     wr_data_o,
  output logic                           push_o,
  output logic [LW+1:0]                  cmd_o
);
  typedef struct packed {
    logic          flag;
    logic          bank;
    logic [LW-1:0] len;
  } cmd_t;

  logic [psx_pkg::MIN_W-1:0] min_len_q, eff_min;
  logic [LW-1:0] run_len_q, run_len_d;
  logic [SW-1:0] shown_q, shown_d;
  logic [BW-1:0] scanned_q, scanned_d;
  logic          halted_q, halted_d;
  logic          bank_q, bank_d;
  logic          accept, printable, long_enough;
  cmd_t          cmd;

  assign cfg_ready_o = 1'b1;
  assign s_ready_o   = !q_full_i;
  assign accept      = s_valid_i && s_ready_o;
  assign printable   = (s_data_i >= psx_pkg::PRINT_LO) && (s_data_i <= psx_pkg::PRINT_HI);
  assign wr_data_o   = s_data_i;
  assign wr_addr_o   = {bank_q, run_len_q[AW-1:0]};
  assign cmd_o       = cmd;

  always_comb begin
    if (min_len_q < psx_pkg::MIN_LEN_LO) begin
      eff_min = psx_pkg::MIN_LEN_LO;
    end else if (min_len_q > psx_pkg::MIN_LEN_HI) begin
      eff_min = psx_pkg::MIN_LEN_HI;
    end else begin
      eff_min = min_len_q;
    end
  end

  assign long_enough = run_len_q >= LW'(eff_min);

  always_comb begin
    run_len_d = run_len_q;
    shown_d   = shown_q;
    scanned_d = scanned_q;
    halted_d  = halted_q;
    bank_d    = bank_q;
    wr_en_o   = 1'b0;
    push_o    = 1'b0;
    cmd.flag  = 1'b0;
    cmd.bank  = bank_q;
    cmd.len   = run_len_q;
    if (accept) begin
      if (!halted_q) begin
        if (scanned_q < BW'(SCAN_LIMIT)) begin
          scanned_d = scanned_q + BW'(1);
          if (printable) begin
            if (run_len_q < LW'(RUN_CAPACITY)) begin
              wr_en_o   = 1'b1;
              run_len_d = run_len_q + LW'(1);
            end
          end else begin
            if (long_enough) begin
              shown_d  = shown_q + SW'(1);
              cmd.flag = shown_d >= SW'(STRING_LIMIT);
              push_o   = 1'b1;
              halted_d = cmd.flag;
            end
            run_len_d = '0;
          end
        end
        // final byte flushes a pending run, never flagged
        if (s_last_i && !halted_d && (run_len_d >= LW'(eff_min)) &&
            (shown_d < SW'(STRING_LIMIT))) begin
          push_o  = 1'b1;
          cmd.len = run_len_d;
        end
      end
      if (push_o) begin
        bank_d = !bank_q;
      end
      if (s_last_i) begin
        run_len_d = '0;
        shown_d   = '0;
        scanned_d = '0;
        halted_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= psx_pkg::MIN_LEN_RESET;
      run_len_q <= '0;
      shown_q   <= '0;
      scanned_q <= '0;
      halted_q  <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        min_len_q <= cfg_data_i;
      end
      run_len_q <= run_len_d;
      shown_q   <= shown_d;
      scanned_q <= scanned_d;
      halted_q  <= halted_d;
      bank_q    <= bank_d;
    end
  end
endmodule

// File: rtl/psx_cmdq.sv
// Two-entry command queue; each entry owns one run bank until drained.
`timescale 1ns / 1ps
module psx_cmdq #(
  parameter int unsigned W = 9
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] cmd_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         full_o,
  output logic [W-1:0] head_o
);
  logic [W-1:0] ent_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// File: rtl/psx_drain.sv
// Back end: run bank memory, character read-out and output register.
`timescale 1ns / 1ps
module psx_drain #(
  parameter int unsigned RUN_CAPACITY = 64,
  localparam int unsigned LW = $clog2(RUN_CAPACITY + 1),
  localparam int unsigned AW = $clog2(RUN_CAPACITY)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [AW:0]                wr_addr_i,
  input  logic [psx_pkg::CHAR_W-1:0] wr_data_i,
  input  logic                       cmd_valid_i,
  input  logic [LW+1:0]              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [psx_pkg::CHAR_W-1:0] m_data_o,
  output logic                       m_last_o,
  output logic                       m_user_o
);
  typedef struct packed {
    logic          flag;
    logic          bank;
    logic [LW-1:0] len;
  } cmd_t;

  logic [psx_pkg::CHAR_W-1:0] run_mem_q [2**(AW+1)];
  logic [psx_pkg::CHAR_W-1:0] rd_data_q;
  logic [AW-1:0] idx_q;
  logic          valid_q, last_q, user_q;
  logic          rd_en, at_end;
  cmd_t          cmd;

  assign cmd       = cmd_i;
  assign rd_en     = cmd_valid_i && (!valid_q || m_ready_i);
  assign at_end    = (LW'(idx_q) + LW'(1)) == cmd.len;
  assign cmd_pop_o = rd_en && at_end;
  assign m_valid_o = valid_q;
  assign m_data_o  = rd_data_q;
  assign m_last_o  = last_q;
  assign m_user_o  = user_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      run_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= run_mem_q[{cmd.bank, idx_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      user_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        idx_q   <= at_end ? '0 : idx_q + AW'(1);
        valid_q <= 1'b1;
        last_q  <= at_end;
        user_q  <= at_end && cmd.flag;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/psx_checker.sv
// Port-level checker for the printable string extractor, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);
  // limit flag only on the closing beat of a string
  `ASSERT_IMPLIES(a_user_on_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // input stalls only while strings are pending, so output must be busy
  `ASSERT_IMPLIES(a_stall_means_busy, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)
  `ASSERT_IMPLIES(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind printable_string_extractor psx_checker u_psx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_o  (cfg_ready_o),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
